>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/tmi_pkg.sv
package tmi_pkg;

  localparam int unsigned PROG_DEPTH_DEF = 4096;
  localparam int unsigned TAPE_CELLS_DEF = 32768;

  localparam int unsigned PROG_ADDR_W = 12;
  localparam int unsigned BYTE_W      = 8;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  localparam logic [BYTE_W-1:0] CMD_RIGHT = 8'h3E;
  localparam logic [BYTE_W-1:0] CMD_LEFT  = 8'h3C;
  localparam logic [BYTE_W-1:0] CMD_INC   = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_DEC   = 8'h2D;
  localparam logic [BYTE_W-1:0] CMD_OUT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CMD_IN    = 8'h2C;
  localparam logic [BYTE_W-1:0] CMD_OPEN  = 8'h5B;
  localparam logic [BYTE_W-1:0] CMD_CLOSE = 8'h5D;

  typedef struct packed {
    logic load_item;
    logic step_start;
    logic exec;
    logic scan;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clearing;
    logic run_ok;
    logic scan_go;
    logic scan_end;
    logic out_full;
  } dp_stat_t;

endpackage

>>> rtl/tmi_req_if.sv
interface tmi_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [tmi_pkg::PROG_ADDR_W-1:0]  prog_addr;
  logic [tmi_pkg::BYTE_W-1:0]       prog_byte;
  logic                             is_last;
  logic [tmi_pkg::BYTE_W-1:0]       in_byte;
  logic                             in_eof;

  modport source (
    output valid, req_type, prog_addr, prog_byte, is_last, in_byte, in_eof,
    input  ready
  );
  modport sink (
    input  valid, req_type, prog_addr, prog_byte, is_last, in_byte, in_eof,
    output ready
  );
endinterface

>>> rtl/tmi_rsp_if.sv
interface tmi_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       out_valid;
  logic [tmi_pkg::BYTE_W-1:0] out_byte;
  logic                       took_input;
  logic                       halted;
  logic                       bracket_error;

  modport source (
    output valid, out_valid, out_byte, took_input, halted, bracket_error,
    input  ready
  );
  modport sink (
    input  valid, out_valid, out_byte, took_input, halted, bracket_error,
    output ready
  );
endinterface

>>> rtl/tmi_ctrl.sv
`include "assert_macros.svh"

module tmi_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_type,
  output logic              req_ready,
  output tmi_pkg::dp_cmd_t  cmd,
  input  tmi_pkg::dp_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;
  logic   acc;

  assign req_ready = (state == S_IDLE) && !stat.clearing;
  assign acc       = req_valid && req_ready;

  always_comb begin
    cmd            = '0;
    cmd.load_item  = acc && (req_type == tmi_pkg::REQ_LOAD);
    cmd.step_start = acc && (req_type == tmi_pkg::REQ_STEP);
    cmd.exec       = (state == S_EXEC);
    cmd.scan       = (state == S_SCAN);
    cmd.out_load   = (state == S_DONE) && !stat.out_full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.step_start && stat.run_ok) begin
            state <= S_EXEC;
          end else if (acc) begin
            state <= S_DONE;
          end
        end
        S_EXEC: begin
          state <= stat.scan_go ? S_SCAN : S_DONE;
        end
        S_SCAN: begin
          if (stat.scan_end) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!stat.out_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_scan_entry, state == S_SCAN, $past(state) == S_EXEC || $past(state) == S_SCAN, "scan entered without a bracket command")

endmodule

>>> rtl/tmi_datapath.sv
`include "assert_macros.svh"

module tmi_datapath #(
  parameter int unsigned PROG_DEPTH = tmi_pkg::PROG_DEPTH_DEF,
  parameter int unsigned TAPE_CELLS = tmi_pkg::TAPE_CELLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tmi_pkg::dp_cmd_t                 cmd,
  output tmi_pkg::dp_stat_t                stat,
  input  logic [tmi_pkg::PROG_ADDR_W-1:0]  prog_addr,
  input  logic [tmi_pkg::BYTE_W-1:0]       prog_byte,
  input  logic                             is_last,
  input  logic [tmi_pkg::BYTE_W-1:0]       in_byte,
  input  logic                             in_eof,
  input  logic                             rsp_ready,
  output logic                             rsp_valid,
  output logic                             out_valid,
  output logic [tmi_pkg::BYTE_W-1:0]       out_byte,
  output logic                             took_input,
  output logic                             halted,
  output logic                             bracket_error
);

  localparam int unsigned AW = $clog2(PROG_DEPTH);
  localparam int unsigned PW = $clog2(PROG_DEPTH + 1);
  localparam int unsigned TW = $clog2(TAPE_CELLS);
  localparam int unsigned XW = ((PW > tmi_pkg::PROG_ADDR_W) ? PW : tmi_pkg::PROG_ADDR_W) + 1;
  localparam int unsigned BW = tmi_pkg::BYTE_W;

  logic [BW-1:0] prog_mem [PROG_DEPTH];
  logic [BW-1:0] tape_mem [TAPE_CELLS];

  logic [PW-1:0] pc, len, sa, depth;
  logic [TW-1:0] cp, clr_cnt;
  logic          clearing, halt, err, scan_fwd;
  logic [BW-1:0] prog_q, tape_q, in_data;
  logic          pend_valid, pend_took;
  logic [BW-1:0] pend_byte;

  logic [XW-1:0] addr_x, len_x, len_new;
  logic          addr_ok;
  logic [PW-1:0] pc_inc, pc_dec, sa_inc, sa_dec, sa_next, depth_next;
  logic          pc_last, cell_zero, inc_d, dec_d, match, sa_edge;
  logic          is_right, is_left, is_inc, is_dec, is_out, is_in, is_open, is_close;
  logic          fwd_go, fwd_fail, back_go, back_fail;
  logic [AW-1:0] pr_addr;
  logic          tape_we;
  logic [TW-1:0] tape_wa;
  logic [BW-1:0] tape_wd;

  assign addr_x  = XW'(prog_addr);
  assign addr_ok = addr_x < XW'(PROG_DEPTH);
  assign len_x   = addr_x + XW'(1);
  assign len_new = (len_x > XW'(PROG_DEPTH)) ? XW'(PROG_DEPTH) : len_x;

  assign pc_inc    = pc + PW'(1);
  assign pc_dec    = pc - PW'(1);
  assign sa_inc    = sa + PW'(1);
  assign sa_dec    = sa - PW'(1);
  assign pc_last   = pc_inc >= len;
  assign cell_zero = (tape_q == '0);

  assign is_right = (prog_q == tmi_pkg::CMD_RIGHT);
  assign is_left  = (prog_q == tmi_pkg::CMD_LEFT);
  assign is_inc   = (prog_q == tmi_pkg::CMD_INC);
  assign is_dec   = (prog_q == tmi_pkg::CMD_DEC);
  assign is_out   = (prog_q == tmi_pkg::CMD_OUT);
  assign is_in    = (prog_q == tmi_pkg::CMD_IN);
  assign is_open  = (prog_q == tmi_pkg::CMD_OPEN);
  assign is_close = (prog_q == tmi_pkg::CMD_CLOSE);

  assign fwd_go    = is_open && cell_zero && !pc_last;
  assign fwd_fail  = is_open && cell_zero && pc_last;
  assign back_go   = is_close && !cell_zero && (pc != '0);
  assign back_fail = is_close && !cell_zero && (pc == '0);

  // bracket depth walk; the direction flips which bracket nests
  assign inc_d      = scan_fwd ? is_open : is_close;
  assign dec_d      = scan_fwd ? is_close : is_open;
  assign depth_next = inc_d ? depth + PW'(1) : (dec_d ? depth - PW'(1) : depth);
  assign match      = (depth_next == '0);
  assign sa_edge    = scan_fwd ? (sa_inc >= len) : (sa == '0);
  assign sa_next    = scan_fwd ? sa_inc : sa_dec;

  always_comb begin
    pr_addr = pc[AW-1:0];
    if (cmd.exec) begin
      pr_addr = is_open ? pc_inc[AW-1:0] : pc_dec[AW-1:0];
    end else if (cmd.scan) begin
      pr_addr = sa_next[AW-1:0];
    end
  end

  always_comb begin
    stat          = '0;
    stat.clearing = clearing;
    stat.run_ok   = !halt && (pc < len);
    stat.scan_go  = fwd_go || back_go;
    stat.scan_end = match || sa_edge;
    stat.out_full = rsp_valid;
  end

  assign tape_we = clearing || (cmd.exec && (is_inc || is_dec || is_in));
  assign tape_wa = clearing ? clr_cnt : cp;
  always_comb begin
    tape_wd = '0;
    if (!clearing) begin
      if (is_inc) begin
        tape_wd = tape_q + BW'(1);
      end else if (is_dec) begin
        tape_wd = tape_q - BW'(1);
      end else begin
        tape_wd = in_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item && addr_ok) begin
      prog_mem[addr_x[AW-1:0]] <= prog_byte;
    end
    prog_q <= prog_mem[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_wa] <= tape_wd;
    end
    tape_q <= tape_mem[cp];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      len       <= '0;
      cp        <= '0;
      halt      <= 1'b0;
      err       <= 1'b0;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      rsp_valid <= 1'b0;
      sa        <= '0;
      depth     <= '0;
      scan_fwd  <= 1'b0;
    end else begin
      if (clearing) begin
        if (clr_cnt == TW'(TAPE_CELLS - 1)) begin
          clearing <= 1'b0;
        end else begin
          clr_cnt <= clr_cnt + TW'(1);
        end
      end

      if (cmd.load_item && is_last) begin
        len  <= len_new[PW-1:0];
        pc   <= '0;
        cp   <= '0;
        halt <= 1'b0;
        err  <= 1'b0;
      end

      if (cmd.step_start && !halt && (pc >= len)) begin
        halt <= 1'b1;
      end

      if (cmd.exec) begin
        if (is_right) begin
          cp <= (cp == TW'(TAPE_CELLS - 1)) ? '0 : cp + TW'(1);
        end else if (is_left) begin
          cp <= (cp == '0) ? TW'(TAPE_CELLS - 1) : cp - TW'(1);
        end
        if (fwd_fail || back_fail) begin
          err  <= 1'b1;
          halt <= 1'b1;
        end else if (fwd_go || back_go) begin
          sa       <= fwd_go ? pc_inc : pc_dec;
          depth    <= PW'(1);
          scan_fwd <= fwd_go;
        end else begin
          pc <= pc_inc;
          if (pc_last) begin
            halt <= 1'b1;
          end
        end
      end

      if (cmd.scan) begin
        if (match) begin
          pc <= sa_inc;
          if (sa_inc >= len) begin
            halt <= 1'b1;
          end
        end else if (sa_edge) begin
          err  <= 1'b1;
          halt <= 1'b1;
        end else begin
          sa    <= sa_next;
          depth <= depth_next;
        end
      end

      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item || cmd.step_start) begin
      pend_valid <= 1'b0;
      pend_byte  <= '0;
      pend_took  <= 1'b0;
      in_data    <= in_eof ? '0 : in_byte;
    end else if (cmd.exec) begin
      pend_valid <= is_out;
      pend_byte  <= is_out ? tape_q : '0;
      pend_took  <= is_in;
    end
    if (cmd.out_load) begin
      out_valid     <= pend_valid;
      out_byte      <= pend_byte;
      took_input    <= pend_took;
      halted        <= halt;
      bracket_error <= err;
    end
  end

  `ASSERT_IMPL(a_err_halts, err, halt, "bracket error without halt")
  `ASSERT_IMPL(a_pc_in_prog, 1'b1, pc <= len, "program counter beyond program end")
  `ASSERT_IMPL(a_no_exec_clear, cmd.exec || cmd.scan, !clearing, "execution during tape clear")

endmodule

>>> rtl/tape_machine_interpreter.sv
// Eight-command tape machine. Load words write one program byte each; the load
// word marked last sets the program length and restarts the program counter,
// cell pointer and flags (the tape keeps its contents). Step words execute one
// command and return one result word. After reset the tape is zeroed by a
// clearing pass over all TAPE_CELLS cells, while req.ready stays low. A load
// word or a step while halted goes straight to its result; an ordinary command
// reads the tape, then does a read-modify-write; a bracket jump then walks the
// program a byte at a time via the program memory's single read port. A new word
// is accepted while an earlier result still sits in the output register.
module tape_machine_interpreter #(
  parameter int unsigned PROG_DEPTH = tmi_pkg::PROG_DEPTH_DEF,
  parameter int unsigned TAPE_CELLS = tmi_pkg::TAPE_CELLS_DEF
) (
  input logic      clk,
  input logic      rst,
  tmi_req_if.sink  req,
  tmi_rsp_if.source rsp
);

  tmi_pkg::dp_cmd_t  cmd;
  tmi_pkg::dp_stat_t stat;

  tmi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  tmi_datapath #(
    .PROG_DEPTH (PROG_DEPTH),
    .TAPE_CELLS (TAPE_CELLS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .prog_addr     (req.prog_addr),
    .prog_byte     (req.prog_byte),
    .is_last       (req.is_last),
    .in_byte       (req.in_byte),
    .in_eof        (req.in_eof),
    .rsp_ready     (rsp.ready),
    .rsp_valid     (rsp.valid),
    .out_valid     (rsp.out_valid),
    .out_byte      (rsp.out_byte),
    .took_input    (rsp.took_input),
    .halted        (rsp.halted),
    .bracket_error (rsp.bracket_error)
  );

endmodule
